// ===== rtl/aqs_pkg.sv =====
// Shared command codes, status codes and debug types for the admission queue scheduler.
package aqs_pkg;

	localparam logic [2:0] CMD_CREATE  = 3'd0;
	localparam logic [2:0] CMD_PUSH    = 3'd1;
	localparam logic [2:0] CMD_REQUEST = 3'd2;
	localparam logic [2:0] CMD_REPLY   = 3'd3;
	localparam logic [2:0] CMD_FINISH  = 3'd4;

	localparam logic [3:0] ST_QUEUED   = 4'd0;
	localparam logic [3:0] ST_FULL     = 4'd1;
	localparam logic [3:0] ST_BUSY     = 4'd2;
	localparam logic [3:0] ST_OFFERED  = 4'd3;
	localparam logic [3:0] ST_EMPTY    = 4'd4;
	localparam logic [3:0] ST_LIMIT    = 4'd5;
	localparam logic [3:0] ST_ADMITTED = 4'd6;
	localparam logic [3:0] ST_REFUSED  = 4'd7;
	localparam logic [3:0] ST_RELEASED = 4'd8;
	localparam logic [3:0] ST_NOPEND   = 4'd9;

	localparam logic [6:0] RESIDENT_MAX = 7'd127;

	localparam logic [2:0] REG_ORDER_MODE = 3'd0;
	localparam logic [2:0] REG_MAX_MEM    = 3'd4;

	// queue occupancy, zero-extended to the widest supported depth
	typedef struct packed {
		logic [8:0] new_count;
		logic [8:0] susp_count;
	} aqs_occ_t;

	// front-to-back handshake
	typedef struct packed {
		logic valid;
		logic pop;
	} aqs_hs_t;

endpackage

// ===== rtl/aqs_front.sv =====
// Front end: accepts transactions, drops unknown commands, buffers them in a two-entry queue.
module aqs_front import aqs_pkg::*; #(
	parameter int SIZE_BITS = 24,
	parameter int ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           cmd,
	input  logic [ID_BITS-1:0]   job_id,
	input  logic [SIZE_BITS-1:0] job_size,
	input  logic                 memory_ok,
	input  logic                 hd_pop,
	output aqs_hs_t              hd_hs,
	output logic [2:0]           hd_cmd,
	output logic [ID_BITS-1:0]   hd_id,
	output logic [SIZE_BITS-1:0] hd_size,
	output logic                 hd_ok
);

	logic [1:0]           vld_q;
	logic [2:0]           cmd_q  [2];
	logic [ID_BITS-1:0]   id_q   [2];
	logic [SIZE_BITS-1:0] size_q [2];
	logic                 ok_q   [2];
	logic                 known;
	logic                 wr;
	logic                 pop;

	assign known = (cmd <= CMD_FINISH);
	assign in_stall = vld_q[1];
	assign wr = in_valid && !in_stall && known;
	assign pop = hd_pop && vld_q[0];

	assign hd_hs.valid = vld_q[0];
	assign hd_hs.pop = pop;
	assign hd_cmd = cmd_q[0];
	assign hd_id = id_q[0];
	assign hd_size = size_q[0];
	assign hd_ok = ok_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 2'b00;
		end else begin
			case ({wr, pop})
				2'b10: vld_q <= {vld_q[0], 1'b1};
				2'b01: vld_q <= {1'b0, vld_q[1]};
				default: vld_q <= vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q[0]  <= cmd_q[1];
			id_q[0]   <= id_q[1];
			size_q[0] <= size_q[1];
			ok_q[0]   <= ok_q[1];
		end
		if (wr) begin
			if ((pop && !vld_q[1]) || (!pop && !vld_q[0])) begin
				cmd_q[0]  <= cmd;
				id_q[0]   <= job_id;
				size_q[0] <= job_size;
				ok_q[0]   <= memory_ok;
			end else begin
				cmd_q[1]  <= cmd;
				id_q[1]   <= job_id;
				size_q[1] <= job_size;
				ok_q[1]   <= memory_ok;
			end
		end
	end

endmodule

// ===== rtl/aqs_back.sv =====
// Back end: owns both job queues and the admission state, executes commands and drives results.
module aqs_back import aqs_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int SIZE_BITS = 24,
	parameter int ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 order_mode,
	input  logic [6:0]           max_in_memory,
	input  aqs_hs_t              hd_hs,
	output logic                 hd_pop,
	input  logic [2:0]           hd_cmd,
	input  logic [ID_BITS-1:0]   hd_id,
	input  logic [SIZE_BITS-1:0] hd_size,
	input  logic                 hd_ok,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           status,
	output logic [ID_BITS-1:0]   out_id,
	output logic [SIZE_BITS-1:0] out_size,
	output logic                 from_suspended,
	output aqs_occ_t             occ
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic {S_IDLE, S_EXEC} state_t;
	state_t state_q;

	logic [ID_BITS-1:0]   nq_id_q   [QUEUE_DEPTH];
	logic [SIZE_BITS-1:0] nq_size_q [QUEUE_DEPTH];
	logic [ID_BITS-1:0]   sq_id_q   [QUEUE_DEPTH];
	logic [SIZE_BITS-1:0] sq_size_q [QUEUE_DEPTH];
	logic [CW-1:0]        new_count_q, susp_count_q;
	logic [IW-1:0]        susp_head_q;
	logic [ID_BITS-1:0]   next_id_q;
	logic [6:0]           resident_q;
	logic                 pending_q, source_q;

	logic [2:0]           cmd_s1;
	logic [ID_BITS-1:0]   id_s1;
	logic [SIZE_BITS-1:0] size_s1;
	logic                 ok_s1;
	logic [QUEUE_DEPTH-1:0] ins_s1;

	logic [QUEUE_DEPTH-1:0] ins;
	logic                 fire;
	logic [CW:0]          tail_sum;
	logic [IW-1:0]        tail;
	logic [IW-1:0]        head_nxt;
	logic                 src_sel;
	logic [ID_BITS-1:0]   cand_id;
	logic [SIZE_BITS-1:0] cand_size;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ins[i] = (CW'(i) == new_count_q) ||
				(order_mode && (CW'(i) < new_count_q) && (hd_size < nq_size_q[i]));
			if (i > 0) ins[i] = ins[i] | ins[i-1];
		end
	end

	assign hd_pop = (state_q == S_IDLE);
	assign fire = (state_q == S_EXEC) && (!out_valid || !out_stall);
	assign tail_sum = {1'b0, CW'(susp_head_q)} + {1'b0, susp_count_q};
	assign tail = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		IW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : IW'(tail_sum);
	assign head_nxt = (susp_head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : susp_head_q + 1'b1;
	assign src_sel = pending_q ? source_q : (susp_count_q != '0);
	assign cand_id = src_sel ? sq_id_q[susp_head_q] : nq_id_q[0];
	assign cand_size = src_sel ? sq_size_q[susp_head_q] : nq_size_q[0];

	assign occ.new_count = 9'(new_count_q);
	assign occ.susp_count = 9'(susp_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			new_count_q <= '0;
			susp_count_q <= '0;
			susp_head_q <= '0;
			next_id_q <= '0;
			resident_q <= '0;
			pending_q <= 1'b0;
			source_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (hd_hs.valid) state_q <= S_EXEC;
				S_EXEC: if (fire) begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
					case (cmd_s1)
						CMD_CREATE: if (!pending_q && new_count_q != DEPTH_C) begin
							new_count_q <= new_count_q + 1'b1;
							next_id_q <= next_id_q + 1'b1;
						end
						CMD_PUSH: if (!pending_q && susp_count_q != DEPTH_C) begin
							susp_count_q <= susp_count_q + 1'b1;
						end
						CMD_REQUEST: if (!pending_q && resident_q < max_in_memory &&
							(susp_count_q != '0 || new_count_q != '0)) begin
							pending_q <= 1'b1;
							source_q <= src_sel;
						end
						CMD_REPLY: if (pending_q) begin
							pending_q <= 1'b0;
							if (ok_s1) begin
								if (source_q) begin
									susp_head_q <= head_nxt;
									susp_count_q <= susp_count_q - 1'b1;
								end else begin
									new_count_q <= new_count_q - 1'b1;
								end
								if (resident_q != RESIDENT_MAX) resident_q <= resident_q + 1'b1;
							end
						end
						CMD_FINISH: if (resident_q != '0) resident_q <= resident_q - 1'b1;
						default: out_valid <= 1'b0;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && hd_hs.valid) begin
			cmd_s1 <= hd_cmd;
			id_s1 <= hd_id;
			size_s1 <= hd_size;
			ok_s1 <= hd_ok;
			ins_s1 <= ins;
		end
		if (fire) begin
			status <= ST_QUEUED;
			out_id <= '0;
			out_size <= '0;
			from_suspended <= 1'b0;
			case (cmd_s1)
				CMD_CREATE: begin
					if (pending_q) status <= ST_BUSY;
					else if (new_count_q == DEPTH_C) status <= ST_FULL;
					else begin
						out_id <= next_id_q;
						out_size <= size_s1;
						for (int i = 0; i < QUEUE_DEPTH; i++) begin
							if (ins_s1[i]) begin
								if (i == 0 || !ins_s1[(i == 0) ? 0 : i-1]) begin
									nq_id_q[i] <= next_id_q;
									nq_size_q[i] <= size_s1;
								end else begin
									nq_id_q[i] <= nq_id_q[(i == 0) ? 0 : i-1];
									nq_size_q[i] <= nq_size_q[(i == 0) ? 0 : i-1];
								end
							end
						end
					end
				end
				CMD_PUSH: begin
					if (pending_q) status <= ST_BUSY;
					else if (susp_count_q == DEPTH_C) status <= ST_FULL;
					else begin
						sq_id_q[tail] <= id_s1;
						sq_size_q[tail] <= size_s1;
						out_id <= id_s1;
						out_size <= size_s1;
						from_suspended <= 1'b1;
					end
				end
				CMD_REQUEST: begin
					if (!pending_q && resident_q >= max_in_memory) status <= ST_LIMIT;
					else if (!pending_q && susp_count_q == '0 && new_count_q == '0)
						status <= ST_EMPTY;
					else begin
						status <= ST_OFFERED;
						out_id <= cand_id;
						out_size <= cand_size;
						from_suspended <= src_sel;
					end
				end
				CMD_REPLY: begin
					if (!pending_q) status <= ST_NOPEND;
					else begin
						status <= ok_s1 ? ST_ADMITTED : ST_REFUSED;
						out_id <= cand_id;
						out_size <= cand_size;
						from_suspended <= source_q;
						if (ok_s1 && !source_q) begin
							for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
								nq_id_q[i] <= nq_id_q[i+1];
								nq_size_q[i] <= nq_size_q[i+1];
							end
						end
					end
				end
				default: status <= ST_RELEASED;
			endcase
		end
	end

endmodule

// ===== rtl/admission_queue_scheduler_top.sv =====
// Top level: configuration registers, front end, back end and checks.
// A transaction goes from its front queue entry through the back end's capture register to the registered result.
// The back end takes a new transaction only after it has executed the last one, and a stalled result holds it.
// The front queue holds two transactions so input is taken while a result waits.
// Reset (arst_n low, asynchronous): queues empty, ids from 0, nothing resident,
// order_mode 0, max_in_memory 8; queue entry contents are not cleared.
module admission_queue_scheduler_top import aqs_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int SIZE_BITS = 24,
	parameter int ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           cmd,
	input  logic [ID_BITS-1:0]   job_id,
	input  logic [SIZE_BITS-1:0] job_size,
	input  logic                 memory_ok,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           status,
	output logic [ID_BITS-1:0]   out_id,
	output logic [SIZE_BITS-1:0] out_size,
	output logic                 from_suspended
);

	logic                 order_mode_q;
	logic [6:0]           max_mem_q;
	aqs_hs_t              hd_hs;
	logic                 hd_pop;
	logic [2:0]           hd_cmd;
	logic [ID_BITS-1:0]   hd_id;
	logic [SIZE_BITS-1:0] hd_size;
	logic                 hd_ok;
	aqs_occ_t             occ;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {25'd0, max_mem_q} : {31'd0, order_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= 1'b0;
			max_mem_q <= 7'd8;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_MAX_MEM[2]) max_mem_q <= pwdata[6:0];
			else order_mode_q <= pwdata[0];
		end
	end

	aqs_front #(.SIZE_BITS(SIZE_BITS), .ID_BITS(ID_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .job_id(job_id), .job_size(job_size), .memory_ok(memory_ok),
		.hd_pop(hd_pop), .hd_hs(hd_hs),
		.hd_cmd(hd_cmd), .hd_id(hd_id), .hd_size(hd_size), .hd_ok(hd_ok)
	);

	aqs_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .SIZE_BITS(SIZE_BITS), .ID_BITS(ID_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.order_mode(order_mode_q), .max_in_memory(max_mem_q),
		.hd_hs(hd_hs), .hd_pop(hd_pop),
		.hd_cmd(hd_cmd), .hd_id(hd_id), .hd_size(hd_size), .hd_ok(hd_ok),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_id(out_id), .out_size(out_size),
		.from_suspended(from_suspended), .occ(occ)
	);

	a_new_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ.new_count <= 9'(QUEUE_DEPTH)) else $error("new queue overfilled");

	a_susp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ.susp_count <= 9'(QUEUE_DEPTH)) else $error("suspended queue overfilled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_NOPEND) else $error("bad status code");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hd_hs.pop |=> !hd_pop) else $error("back end took two transactions back to back");

endmodule
